@@ sv/swuc_pkg.sv @@
// Shared types and constants for the stack with undo history.
package swuc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int HIST_DEPTH  = 4;
  localparam int HCNT_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_UNDO = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_STACK_EMPTY   = 2'd1,
    ST_HISTORY_EMPTY = 2'd2,
    ST_STACK_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_RESP = 1'b1
  } fsm_t;

endpackage

@@ sv/stack_with_undo_cache_core.sv @@
// Bounded LIFO stack with a four-deep undo history of popped values.
//
// Input channel (in_*): one transfer carries one operation, push, pop or undo
// of the latest pop; mode three does nothing. Result channel (out_*): every
// operation answers with exactly one transfer carrying the popped value (zero
// unless a pop succeeded), a status code, the history fill and an
// empty-stack flag, all as they stand after the operation.
//
// Timing: an operation is taken in the idle state (memory access issued, counts
// updated) and its result is loaded into the output register from the response
// state once that register is free, and out_tvalid rises with that load. No new
// operation is taken before that load; the response state covers the registered
// read of the stack memory. Only one operation is in flight at a time.
//
// Stalls: the output register holds a result until it is taken; the next
// operation is still accepted while it waits, its result then waits in the
// response state until the output register frees.
//
// Reset (rst_n low, synchronous): stack and history become empty. Memory and
// history entries are not cleared; only entries below the counts are read.
module stack_with_undo_cache_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] mode, [33:2] push_value, [39:34] zero
  input  logic [swuc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] pop_value, [33:32] status, [36:34] history_count,
  // [37] stack_empty, [39:38] zero
  output logic [swuc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int AW = swuc_pkg::ADDR_W;
  localparam int CW = swuc_pkg::CNT_W;
  localparam int DW = swuc_pkg::DATA_W;
  localparam int HD = swuc_pkg::HIST_DEPTH;
  localparam int HW = swuc_pkg::HCNT_W;
  localparam int OUT_TDATA_W_L = swuc_pkg::OUT_TDATA_W;

  // stack memory, one write and one registered read port
  logic [DW-1:0] stack_mem [swuc_pkg::STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata_r;

  // history: shift line, index 0 newest
  logic [DW-1:0] hist_r [HD];

  swuc_pkg::fsm_t    state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [HW-1:0]     fill_r, fill_nxt;

  // response held between the access cycle and the output load
  swuc_pkg::status_t rsp_status_r, rsp_status_nxt;
  logic [HW-1:0]     rsp_hcnt_r, rsp_hcnt_nxt;
  logic              rsp_empty_r, rsp_empty_nxt;
  logic              rsp_pop_r, rsp_pop_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W_L-1:0] out_data_r, out_data_nxt;

  swuc_pkg::mode_t   in_mode;
  logic [DW-1:0]     in_value;
  logic              accept;
  logic              stack_full;
  logic              out_free;
  logic              hist_push;   // shift the popped value in
  logic              hist_take;   // shift the newest entry out
  logic [DW-1:0]     pop_data;

  assign in_mode    = swuc_pkg::mode_t'(in_tdata[1:0]);
  assign in_value   = in_tdata[DW+1:2];
  assign in_tready  = (state_r == swuc_pkg::FSM_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign stack_full = (cnt_r == CW'(swuc_pkg::STACK_DEPTH));
  assign out_free   = !out_valid_r || out_tready;
  assign pop_data   = rsp_pop_r ? mem_rdata_r : '0;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    rsp_status_nxt = rsp_status_r;
    rsp_hcnt_nxt   = rsp_hcnt_r;
    rsp_empty_nxt  = rsp_empty_r;
    rsp_pop_nxt    = rsp_pop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_wdata      = in_value;
    mem_re         = 1'b0;
    mem_raddr      = AW'(cnt_r - CW'(1));
    hist_push      = 1'b0;
    hist_take      = 1'b0;
    case (state_r)
      swuc_pkg::FSM_IDLE: begin
        if (accept) begin
          rsp_status_nxt = swuc_pkg::ST_OK;
          rsp_pop_nxt    = 1'b0;
          case (in_mode)
            swuc_pkg::MODE_PUSH: begin
              if (stack_full) begin
                rsp_status_nxt = swuc_pkg::ST_STACK_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            swuc_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                rsp_status_nxt = swuc_pkg::ST_STACK_EMPTY;
              end else begin
                mem_re      = 1'b1;
                rsp_pop_nxt = 1'b1;
                cnt_nxt     = cnt_r - CW'(1);
                if (fill_r != HW'(HD)) begin
                  fill_nxt = fill_r + HW'(1);
                end
              end
            end
            swuc_pkg::MODE_UNDO: begin
              if (fill_r == '0) begin
                rsp_status_nxt = swuc_pkg::ST_HISTORY_EMPTY;
              end else if (stack_full) begin
                rsp_status_nxt = swuc_pkg::ST_STACK_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = hist_r[0];
                hist_take = 1'b1;
                cnt_nxt   = cnt_r + CW'(1);
                fill_nxt  = fill_r - HW'(1);
              end
            end
            default: ;  // no operation
          endcase
          rsp_hcnt_nxt  = fill_nxt;
          rsp_empty_nxt = (cnt_nxt == '0);
          state_nxt     = swuc_pkg::FSM_RESP;
        end
      end
      swuc_pkg::FSM_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, rsp_empty_r, rsp_hcnt_r, rsp_status_r, pop_data};
          hist_push     = rsp_pop_r;
          rsp_pop_nxt   = 1'b0;
          state_nxt     = swuc_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = swuc_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swuc_pkg::FSM_IDLE;
      cnt_r        <= '0;
      fill_r       <= '0;
      rsp_status_r <= swuc_pkg::ST_OK;
      rsp_hcnt_r   <= '0;
      rsp_empty_r  <= 1'b1;
      rsp_pop_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      rsp_status_r <= rsp_status_nxt;
      rsp_hcnt_r   <= rsp_hcnt_nxt;
      rsp_empty_r  <= rsp_empty_nxt;
      rsp_pop_r    <= rsp_pop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // stack memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= stack_mem[mem_raddr];
    end
  end

  // history shift line; oldest entry falls off the end on insert
  always_ff @(posedge clk) begin
    if (hist_push) begin
      hist_r[0] <= mem_rdata_r;
      for (int i = 1; i < HD; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (hist_take) begin
      for (int i = 0; i < HD - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- assertions ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(swuc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= HW'(HD))
    else $error("history fill beyond depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second operation taken while one is in flight");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == swuc_pkg::MODE_POP && cnt_r != '0) |=>
      (rsp_pop_r && cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not read the stack");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[DW+1:DW] != swuc_pkg::ST_OK) |->
      (out_data_r[DW-1:0] == '0))
    else $error("failed operation returned a value");

endmodule
